FILE: rtl/core/ssr_pkg.sv
// ssr_pkg: shared constants and types for the session segment reassembler.
// No dependencies; used by ssr_frame_store and session_segment_reassembler.
`timescale 1ns / 1ps
`default_nettype none

package ssr_pkg;

  localparam int BUFFER_BYTES_DEF = 64;   // default frame buffer depth
  localparam int MAX_RESULTS      = 64;   // most data beats per delivery
  localparam int RES_IW           = 6;    // index width for MAX_RESULTS beats

  localparam logic [6:0] FRAME_SIZE_RST = 7'd30;

  // status codes carried in each result beat
  localparam logic [1:0] ST_PROGRESS = 2'd0;
  localparam logic [1:0] ST_COMPLETE = 2'd1;
  localparam logic [1:0] ST_SESS_ERR = 2'd2;
  localparam logic [1:0] ST_DIRECT   = 2'd3;

  // one pending output job: a lone status beat or a buffer delivery
  typedef struct packed {
    logic              single;    // one status beat, no frame bytes
    logic [1:0]        status;
    logic [8:0]        count;     // received_count carried on every beat
    logic [RES_IW-1:0] last_idx;  // index of the final frame byte
  } job_t;

endpackage

`default_nettype wire

FILE: rtl/core/ssr_frame_store.sv
// ssr_frame_store: frame buffer memory plus the output sequencer that turns
// one job into its result beats. Depends on ssr_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ssr_frame_store #(
  parameter int BUFFER_BYTES = ssr_pkg::BUFFER_BYTES_DEF,
  parameter int AW           = $clog2(BUFFER_BYTES)
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  // buffer write port
  input  wire logic             wr_en,
  input  wire logic [AW-1:0]    wr_addr,
  input  wire logic [7:0]       wr_data,
  // job handoff
  input  wire logic             job_load,
  input  wire ssr_pkg::job_t    job_in,
  output logic                  job_free,
  // result stream
  output logic                  out_tvalid,
  input  wire logic             out_tready,
  output logic [23:0]           out_tdata,  // status[1:0], received_count[10:2],
                                            // frame_byte[18:11], zero[23:19]
  output logic                  out_tuser,  // result_kind
  output logic                  out_tlast   // last_of_run
);

  logic [7:0]                  mem [BUFFER_BYTES];

  logic                        job_vld_r;
  ssr_pkg::job_t               job_r;
  logic [ssr_pkg::RES_IW-1:0]  idx_r;

  logic                        b_vld_r;
  logic                        b_kind_r;
  logic [1:0]                  b_status_r;
  logic [8:0]                  b_count_r;
  logic                        b_last_r;
  logic [7:0]                  rd_data_r;

  logic                        b_load;
  logic                        issue;
  logic                        is_last;
  logic                        job_done;
  logic [AW-1:0]               rd_addr;
  logic [7:0]                  byte_out;

  assign b_load   = !b_vld_r || out_tready;
  assign issue    = job_vld_r && b_load;
  assign is_last  = job_r.single || (idx_r == job_r.last_idx);
  assign job_done = issue && is_last;
  assign job_free = !job_vld_r || job_done;
  assign rd_addr  = AW'(idx_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      job_vld_r <= 1'b0;
      b_vld_r   <= 1'b0;
    end else begin
      if (job_load) begin
        job_vld_r <= 1'b1;
      end else if (job_done) begin
        job_vld_r <= 1'b0;
      end
      if (b_load) begin
        b_vld_r <= issue;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (job_load) begin
      job_r <= job_in;
      idx_r <= '0;
    end else if (issue) begin
      idx_r <= idx_r + 1'b1;
    end
    if (issue) begin
      b_kind_r   <= !job_r.single;
      b_status_r <= job_r.status;
      b_count_r  <= job_r.count;
      b_last_r   <= is_last;
    end
  end

  // buffer: one write and one registered read per cycle
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (issue) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign byte_out   = b_kind_r ? rd_data_r : 8'd0;
  assign out_tvalid = b_vld_r;
  assign out_tuser  = b_kind_r;
  assign out_tlast  = b_last_r;
  assign out_tdata  = {5'd0, byte_out, b_count_r, b_status_r};

endmodule

`default_nettype wire

FILE: rtl/core/session_segment_reassembler.sv
// session_segment_reassembler: top level. Segment bookkeeping, session check
// and buffer write control. Depends on ssr_pkg and ssr_frame_store.
`timescale 1ns / 1ps
`default_nettype none

// Takes one segment byte per beat and rebuilds a frame of frame_size bytes in
// an internal buffer. Beats that do not end a segment at most write the buffer
// and give no result. A segment-end beat gives either one status beat
// (in progress, session error) or a frame delivery: one data beat per frame
// byte, capped at min(BUFFER_BYTES, 64), each carrying the status and the
// byte count, with tlast on the final beat. An empty delivery is one status
// beat. Rate: one input beat per cycle while the output side keeps up; a
// frame delivery holds in_tready low until its last byte issues, as the
// buffer's single read port feeds one output beat per cycle unless stalled.
// out_tvalid is registered: a taken beat loads the job register, which then
// issues into the output beat register. The user must write frame_size through
// cfg_wen/cfg_wdata only while the block is idle; the block does not enforce it.

module session_segment_reassembler #(
  parameter int BUFFER_BYTES = ssr_pkg::BUFFER_BYTES_DEF  // 8 .. 256
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // configuration
  input  wire logic        cfg_wen,
  input  wire logic [6:0]  cfg_wdata,   // frame_size
  // segment byte stream
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [31:0] in_tdata,    // session_number[3:0], segment_length[11:4],
                                        // byte_offset[19:12], data_byte[27:20], zero[31:28]
  input  wire logic [1:0]  in_tuser,    // direct_mode[0], start_flag[1]
  input  wire logic        in_tlast,    // segment_end
  // result stream
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [23:0]      out_tdata,   // status[1:0], received_count[10:2],
                                        // frame_byte[18:11], zero[23:19]
  output logic             out_tuser,   // result_kind
  output logic             out_tlast    // last_of_run
);

  localparam int AW  = $clog2(BUFFER_BYTES);
  // delivered bytes never exceed the buffer or the result limit
  localparam int CAP = (BUFFER_BYTES < ssr_pkg::MAX_RESULTS) ?
                       BUFFER_BYTES : ssr_pkg::MAX_RESULTS;

  // configuration and session state
  logic [6:0]    frame_size_r;
  logic [8:0]    byte_count_r, byte_count_nxt;
  logic [3:0]    active_session_r, active_session_nxt;

  // input fields
  logic          direct;
  logic          start;
  logic [3:0]    sess;
  logic [7:0]    seglen;
  logic [7:0]    offs;
  logic [7:0]    dbyte;
  logic          segend;

  logic          accept;
  logic          job_free;

  logic [8:0]    cnt_base;
  logic [3:0]    sess_base;
  logic [9:0]    pos;
  logic [8:0]    sum;
  logic          in_seg;

  logic          wr_en;
  logic [AW-1:0] wr_addr;

  logic          job_load;
  ssr_pkg::job_t job;
  logic          deliver;
  logic [8:0]    dlen;
  logic [8:0]    dn;

  assign sess   = in_tdata[3:0];
  assign seglen = in_tdata[11:4];
  assign offs   = in_tdata[19:12];
  assign dbyte  = in_tdata[27:20];
  assign direct = in_tuser[0];
  assign start  = in_tuser[1];
  assign segend = in_tlast;

  assign in_tready = job_free;
  assign accept    = in_tvalid && in_tready;

  // start flag takes effect before the session check of the same beat
  assign cnt_base  = start ? 9'd0 : byte_count_r;
  assign sess_base = start ? sess : active_session_r;
  assign pos       = {1'b0, cnt_base} + {2'b00, offs};
  assign sum       = cnt_base + {1'b0, seglen};   // wraps at 9 bits
  assign in_seg    = offs < seglen;

  always_comb begin
    byte_count_nxt     = byte_count_r;
    active_session_nxt = active_session_r;
    wr_en              = 1'b0;
    wr_addr            = AW'(offs);
    job_load           = 1'b0;
    deliver            = 1'b0;
    dlen               = 9'd0;
    job.single         = 1'b1;
    job.status         = ssr_pkg::ST_PROGRESS;
    job.count          = 9'd0;
    job.last_idx       = '0;

    if (direct) begin
      // direct segment: bytes land at their offset
      wr_en   = in_seg && ({2'b00, offs} < 10'(BUFFER_BYTES));
      wr_addr = AW'(offs);
      if (segend) begin
        byte_count_nxt     = {1'b0, seglen};
        active_session_nxt = 4'd0;
        job_load           = 1'b1;
        deliver            = 1'b1;
        dlen               = {1'b0, seglen};
        job.status         = ssr_pkg::ST_DIRECT;
        job.count          = {1'b0, seglen};
      end
    end else begin
      byte_count_nxt     = cnt_base;
      active_session_nxt = sess_base;
      if (sess != sess_base) begin
        // mismatch: drop the byte, clear the session at segment end
        if (segend) begin
          byte_count_nxt     = 9'd0;
          active_session_nxt = 4'd0;
          job_load           = 1'b1;
          job.status         = ssr_pkg::ST_SESS_ERR;
        end
      end else begin
        wr_en   = in_seg && (pos < {3'b000, frame_size_r}) &&
                  (pos < 10'(BUFFER_BYTES));
        wr_addr = AW'(pos);
        if (segend) begin
          job_load = 1'b1;
          if (sum == {2'b00, frame_size_r}) begin
            byte_count_nxt = sum;
            deliver        = 1'b1;
            dlen           = {2'b00, frame_size_r};
            job.status     = ssr_pkg::ST_COMPLETE;
            job.count      = sum;
          end else if (sum > {2'b00, frame_size_r}) begin
            // overrun: count went past the frame
            byte_count_nxt     = 9'd0;
            active_session_nxt = 4'd0;
            job.status         = ssr_pkg::ST_SESS_ERR;
          end else begin
            byte_count_nxt = sum;
            job.status     = ssr_pkg::ST_PROGRESS;
            job.count      = sum;
          end
        end
      end
    end

    // delivery length, clamped; zero length falls back to one status beat
    dn = (dlen > 9'(CAP)) ? 9'(CAP) : dlen;
    if (deliver && (dn != 9'd0)) begin
      job.single   = 1'b0;
      job.last_idx = ssr_pkg::RES_IW'(dn - 9'd1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_size_r     <= ssr_pkg::FRAME_SIZE_RST;
      byte_count_r     <= 9'd0;
      active_session_r <= 4'd0;
    end else begin
      if (cfg_wen) begin
        frame_size_r <= cfg_wdata;
      end
      if (accept) begin
        byte_count_r     <= byte_count_nxt;
        active_session_r <= active_session_nxt;
      end
    end
  end

  ssr_frame_store #(
    .BUFFER_BYTES (BUFFER_BYTES),
    .AW           (AW)
  ) u_store (
    .clk        (clk),
    .rst_n      (rst_n),
    .wr_en      (accept && wr_en),
    .wr_addr    (wr_addr),
    .wr_data    (dbyte),
    .job_load   (accept && job_load),
    .job_in     (job),
    .job_free   (job_free),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

endmodule

`default_nettype wire
